// ===== sv/fcb_pkg.sv =====
package fcb_pkg;

    localparam int FRAME_LEN = 12;
    localparam int BODY_LEN  = 10;
    localparam int HALF_LEN  = BODY_LEN / 2;
    localparam int IDX_W     = $clog2(FRAME_LEN);

    localparam logic [7:0] LEN_BYTE = 8'd8;
    localparam logic [7:0] SUM_INIT = 8'hff;

    // widths of the raw sums over one ten-byte body
    localparam int A_W   = 12;
    localparam int PLO_W = 14;
    localparam int PHI_W = 12;
    localparam int B_W   = 15;

    typedef logic [7:0]                t_byte;
    typedef logic [BODY_LEN-1:0][7:0]  t_body;
    typedef logic [FRAME_LEN-1:0][7:0] t_frame;

    typedef struct packed {
        t_body body;
        t_byte chk_hi;
        t_byte chk_lo;
    } t_sum_out;

endpackage

// ===== sv/fcb_sum_pipe.sv =====
module fcb_sum_pipe (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  fcb_pkg::t_body   i_body,
    output logic             o_valid,
    input  logic             i_ready,
    output fcb_pkg::t_sum_out o_data
);
    import fcb_pkg::*;

    // stage 1: sum A and the two halves of the weighted sum B
    logic               r_v1;
    t_body              r_body1;
    logic [A_W-1:0]     r_a1, n_a1;
    logic [PLO_W-1:0]   r_plo1, n_plo1;
    logic [PHI_W-1:0]   r_phi1, n_phi1;

    // stage 2: full B and first end-around fold
    logic               r_v2;
    t_body              r_body2;
    logic [8:0]         r_a2, n_a2;
    logic [8:0]         r_b2, n_b2;
    logic [B_W-1:0]     b_raw;

    // stage 3: second fold
    logic               r_v3;
    t_body              r_body3;
    t_byte              r_hi3, r_lo3, n_hi3, n_lo3;

    logic rdy1, rdy2, rdy3;

    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    always_comb begin
        n_a1   = A_W'(SUM_INIT);
        n_plo1 = '0;
        n_phi1 = '0;
        for (int j = 0; j < BODY_LEN; j++) begin
            n_a1 = n_a1 + A_W'(i_body[j]);
            if (j < HALF_LEN) begin
                n_plo1 = n_plo1 + PLO_W'(BODY_LEN - j) * PLO_W'(i_body[j]);
            end else begin
                n_phi1 = n_phi1 + PHI_W'(BODY_LEN - j) * PHI_W'(i_body[j]);
            end
        end
    end

    always_comb begin
        b_raw = B_W'(int'(SUM_INIT) * (BODY_LEN + 1)) + B_W'(r_plo1) + B_W'(r_phi1);
        n_a2  = 9'(r_a1[7:0]) + 9'(r_a1[A_W-1:8]);
        n_b2  = 9'(b_raw[7:0]) + 9'(b_raw[B_W-1:8]);
    end

    always_comb begin
        n_lo3 = r_a2[7:0] + 8'(r_a2[8]);
        n_hi3 = r_b2[7:0] + 8'(r_b2[8]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_body1 <= i_body;
            r_a1    <= n_a1;
            r_plo1  <= n_plo1;
            r_phi1  <= n_phi1;
        end
        if (rdy2 && r_v1) begin
            r_body2 <= r_body1;
            r_a2    <= n_a2;
            r_b2    <= n_b2;
        end
        if (rdy3 && r_v2) begin
            r_body3 <= r_body2;
            r_hi3   <= n_hi3;
            r_lo3   <= n_lo3;
        end
    end

    assign o_valid       = r_v3;
    assign o_data.body   = r_body3;
    assign o_data.chk_hi = r_hi3;
    assign o_data.chk_lo = r_lo3;

endmodule

// ===== sv/fcb_serialiser.sv =====
module fcb_serialiser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  fcb_pkg::t_sum_out i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_byte,
    output logic              o_last
);
    import fcb_pkg::*;

    logic             r_v;
    logic [IDX_W-1:0] r_idx;
    t_frame           r_buf;
    t_frame           n_buf;
    logic             last, take, load;

    assign last    = (r_idx == IDX_W'(FRAME_LEN - 1));
    assign take    = r_v && i_ready;
    assign o_ready = !r_v || (take && last);
    assign load    = i_valid && o_ready;

    always_comb begin
        for (int k = 0; k < BODY_LEN; k++) begin
            n_buf[k] = i_data.body[k];
        end
        n_buf[BODY_LEN]     = i_data.chk_hi;
        n_buf[BODY_LEN + 1] = i_data.chk_lo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= 1'b0;
            r_idx <= '0;
        end else if (load) begin
            r_v   <= 1'b1;
            r_idx <= '0;
        end else if (take) begin
            if (last) begin
                r_v   <= 1'b0;
                r_idx <= '0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_buf <= n_buf;
    end

    assign o_valid = r_v;
    assign o_byte  = r_buf[r_idx];
    assign o_last  = last;

endmodule

// ===== sv/command_frame_builder_fletcher16_core.sv =====
// Command frame builder. Each accepted command (command byte plus two signed
// 32-bit values) yields a 12-byte frame on the byte-wide output: command
// byte, length byte 8, both values big-endian, then the Fletcher-16
// checksum of the first ten bytes, high byte first; o_frame_end marks the
// last byte. The checksum is computed in a three-stage pipeline and the
// frame is then shifted out one byte per cycle while the output is ready,
// so the byte-wide output sets the sustained command rate. The serialiser
// loads the next command in the same cycle as the last byte of the previous
// frame is taken, and up to four commands may be in flight. Each frame's
// bytes pass the pipeline stages and then the serialiser's buffer.
module command_frame_builder_fletcher16_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_command_code,
    input  logic signed [31:0] i_first_value,
    input  logic signed [31:0] i_second_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_frame_byte,
    output logic        o_frame_end
);
    import fcb_pkg::*;

    t_body    body;
    t_sum_out sum_data;
    logic     sum_valid, ser_ready;

    always_comb begin
        body[0] = i_command_code;
        body[1] = LEN_BYTE;
        for (int k = 0; k < 4; k++) begin
            body[2 + k] = i_first_value[31 - 8*k -: 8];
            body[6 + k] = i_second_value[31 - 8*k -: 8];
        end
    end

    fcb_sum_pipe u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_body  (body),
        .o_valid (sum_valid),
        .i_ready (ser_ready),
        .o_data  (sum_data)
    );

    fcb_serialiser u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sum_valid),
        .o_ready (ser_ready),
        .i_data  (sum_data),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_byte  (o_frame_byte),
        .o_last  (o_frame_end)
    );

endmodule

// ===== sv/fcb_checker.sv =====
module fcb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [7:0]  i_command_code,
    input logic [31:0] i_first_value,
    input logic [31:0] i_second_value,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_frame_byte,
    input logic        o_frame_end
);
    import fcb_pkg::*;

    logic             in_acc, out_acc;
    logic [IDX_W-1:0] r_pos;
    logic [2:0]       r_pending;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_pending <= '0;
        end else begin
            if (out_acc) begin
                r_pos <= o_frame_end ? '0 : r_pos + 1'b1;
            end
            r_pending <= r_pending + 3'(in_acc) - 3'(out_acc && o_frame_end);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_frame_byte)
            && $stable(o_frame_end))
        else $error("output transaction changed while stalled");

    a_end_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_frame_end == (r_pos == IDX_W'(FRAME_LEN - 1))))
        else $error("frame end flag not on twelfth byte");

    a_len_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_pos == IDX_W'(1) |-> o_frame_byte == LEN_BYTE)
        else $error("length byte wrong");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pending != 3'd0)
        else $error("output without an outstanding command");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 3'd4)
        else $error("too many commands in flight");

endmodule

bind command_frame_builder_fletcher16_core fcb_checker u_fcb_checker (.*);
